>>> rtl/did_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// did_pkg
// Shared codes and field widths of the deferred interrupt dispatcher.
// ----------------------------------------------------------------------------
package did_pkg;

  localparam int ACTION_W    = 2;
  localparam int LINE_W      = 5;
  localparam int KIND_W      = 3;
  localparam int COUNT_OUT_W = 32;
  localparam int REG_W       = 32;
  localparam int ADDR_W      = 3;

  // word index of the handler enable register
  localparam int REG_HANDLER_ENABLE = 0;

  typedef enum logic [ACTION_W-1:0] {
    ACT_RAISE   = 2'd0,
    ACT_DONE    = 2'd1,
    ACT_SAVE    = 2'd2,
    ACT_RESTORE = 2'd3
  } action_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACCEPTED   = 3'd0,
    KIND_DISPATCH   = 3'd1,
    KIND_DONE_SCHED = 3'd2,
    KIND_DONE       = 3'd3,
    KIND_SAVE       = 3'd4
  } kind_e;

endpackage

>>> rtl/did_count_lanes.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// did_count_lanes
// One saturating event counter per line. Each selected lane adds the shared addend; the
// served lane is cleared and its updated value is handed out.
// ----------------------------------------------------------------------------
module did_count_lanes #(
  parameter int LINES      = 32,
  parameter int COUNT_BITS = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  upd_i,
  input  logic [LINES-1:0]                      add_sel_i,
  input  logic [COUNT_BITS-1:0]                 add_val_i,
  input  logic                                  serve_i,
  input  logic [((LINES > 1) ? $clog2(LINES) : 1)-1:0] serve_idx_i,
  output logic [COUNT_BITS-1:0]                 serve_count_o
);

  localparam int LW = (LINES > 1) ? $clog2(LINES) : 1;

  logic [COUNT_BITS-1:0] cnt_q [LINES];
  logic [COUNT_BITS-1:0] upd   [LINES];

  always_comb begin
    logic [COUNT_BITS:0] sum;
    sum = '0;
    for (int i = 0; i < LINES; i++) begin
      sum = {1'b0, cnt_q[i]} + (add_sel_i[i] ? {1'b0, add_val_i} : '0);
      upd[i] = sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];
    end
  end

  assign serve_count_o = upd[serve_idx_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LINES; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (upd_i) begin
      for (int i = 0; i < LINES; i++) begin
        cnt_q[i] <= (serve_i && (serve_idx_i == LW'(i))) ? '0 : upd[i];
      end
    end
  end

endmodule

>>> rtl/deferred_irq_dispatcher_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deferred_irq_dispatcher_core
// Pending interrupt accumulator with per-line event counts, hold flag and
// highest-line-first dispatch runs.
// ----------------------------------------------------------------------------
//  channel   | handshake                         | payload
//  ----------+-----------------------------------+-------------------------------
//  request   | start / busy                      | action, line_number, retry,
//            |                                   | restore_value
//  result    | done_o strobe, one cycle          | kind, served_line,
//            |                                   | served_count, previous_hold
//  config    | psel/penable/pwrite, pready = 1   | paddr, pwdata, prdata
//
//  One request per cycle while busy is low; it enters the input register,
//  then one pass of encoder and lane update fills the result register that
//  strobes done_o. busy is high during reset and the cycle after it,
//  then stays low. The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
module deferred_irq_dispatcher_core #(
  parameter int LINES      = 32,
  parameter int COUNT_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // request
  input  logic                             start,
  output logic                             busy,
  input  logic [did_pkg::ACTION_W-1:0]     action_i,
  input  logic [did_pkg::LINE_W-1:0]       line_number_i,
  input  logic                             retry_i,
  input  logic                             restore_value_i,
  // result
  output logic                             done_o,
  output logic [did_pkg::KIND_W-1:0]       kind_o,
  output logic [did_pkg::LINE_W-1:0]       served_line_o,
  output logic [did_pkg::COUNT_OUT_W-1:0]  served_count_o,
  output logic                             previous_hold_o,
  // configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [did_pkg::ADDR_W-1:0]       paddr,
  input  logic [did_pkg::REG_W-1:0]        pwdata,
  output logic [did_pkg::REG_W-1:0]        prdata,
  output logic                             pready
);

  localparam int LW    = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int LineW = did_pkg::LINE_W;
  localparam int CntW  = did_pkg::COUNT_OUT_W;

  // ---------------- configuration ----------------
  logic [did_pkg::REG_W-1:0] en_q;
  logic                      reg_sel;

  assign reg_sel = (paddr[did_pkg::ADDR_W-1:2] == 1'(did_pkg::REG_HANDLER_ENABLE));
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? en_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= '0;
    end else if (psel && penable && pwrite && reg_sel) begin
      en_q <= pwdata;
    end
  end

  // ---------------- input register ----------------
  logic                busy_q;
  logic                item_v_q;
  did_pkg::action_e    act_q;
  logic [LineW-1:0]    line_q;
  logic                retry_q;
  logic                rval_q;

  assign busy = busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b1;
      item_v_q <= 1'b0;
    end else begin
      busy_q   <= 1'b0;
      item_v_q <= start && !busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy_q) begin
      act_q   <= did_pkg::action_e'(action_i);
      line_q  <= line_number_i;
      retry_q <= retry_i;
      rval_q  <= restore_value_i;
    end
  end

  // ---------------- dispatcher state ----------------
  logic [LINES-1:0]      pend_q, pend_d;
  logic                  hold_q, hold_d;
  logic                  disp_q, disp_d;
  logic [LW-1:0]         cur_q, cur_d;
  logic [COUNT_BITS-1:0] cur_cnt_q, cur_cnt_d;
  logic                  frr_q, frr_d;

  logic [63:0]           en_wide;
  logic [LINES-1:0]      en_lines;
  logic                  raise_ok;
  logic [LINES-1:0]      raise_sel, retry_sel, pend_in, cand, keep;
  logic                  found;
  logic [LW-1:0]         idx;
  logic                  adv;
  logic [COUNT_BITS-1:0] serve_cnt;

  did_pkg::kind_e        kind_d;
  logic [LineW-1:0]      sline_d;
  logic [CntW-1:0]       scnt_d;
  logic                  prev_d;

  assign en_wide  = 64'(en_q);
  assign en_lines = en_wide[LINES-1:0];
  assign raise_ok = (act_q == did_pkg::ACT_RAISE) && (int'(line_q) < LINES);

  always_comb begin
    for (int i = 0; i < LINES; i++) begin
      raise_sel[i] = raise_ok && (int'(line_q) == i);
      retry_sel[i] = (act_q == did_pkg::ACT_DONE) && disp_q && retry_q && (cur_q == LW'(i));
    end
  end

  assign pend_in = pend_q | raise_sel;
  assign cand    = pend_in & en_lines;

  // highest pending line with a handler
  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = 0; i < LINES; i++) begin
      if (cand[i]) begin
        found = 1'b1;
        idx   = LW'(i);
      end
    end
    for (int i = 0; i < LINES; i++) begin
      keep[i] = found && (LW'(i) < idx);
    end
  end

  did_count_lanes #(
    .LINES      (LINES),
    .COUNT_BITS (COUNT_BITS)
  ) u_lanes (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .upd_i         (item_v_q),
    .add_sel_i     (raise_sel | retry_sel),
    .add_val_i     (raise_ok ? COUNT_BITS'(1) : cur_cnt_q),
    .serve_i       (adv && found),
    .serve_idx_i   (idx),
    .serve_count_o (serve_cnt)
  );

  always_comb begin
    pend_d    = pend_in;
    hold_d    = hold_q;
    disp_d    = disp_q;
    cur_d     = cur_q;
    cur_cnt_d = cur_cnt_q;
    frr_d     = frr_q;
    adv       = 1'b0;
    kind_d    = did_pkg::KIND_ACCEPTED;
    sline_d   = '0;
    scnt_d    = '0;
    prev_d    = 1'b0;

    case (act_q)
      did_pkg::ACT_RAISE: begin
        if (raise_ok && !hold_q && !disp_q) begin
          hold_d = 1'b1;
          frr_d  = 1'b1;
          adv    = 1'b1;
        end
      end
      did_pkg::ACT_DONE: begin
        if (disp_q) begin
          cur_cnt_d = '0;
          adv       = 1'b1;
        end
      end
      did_pkg::ACT_SAVE: begin
        kind_d = did_pkg::KIND_SAVE;
        prev_d = hold_q;
        hold_d = 1'b1;
      end
      did_pkg::ACT_RESTORE: begin
        if (!disp_q && !rval_q && (pend_q != '0)) begin
          frr_d = 1'b0;
          adv   = 1'b1;
        end else begin
          hold_d = rval_q;
        end
      end
      default: begin
        kind_d = did_pkg::KIND_ACCEPTED;
      end
    endcase

    if (adv) begin
      // lines passed by the search without a handler are dropped
      pend_d = pend_in & keep;
      if (found) begin
        cur_d     = idx;
        cur_cnt_d = serve_cnt;
        disp_d    = 1'b1;
        kind_d    = did_pkg::KIND_DISPATCH;
        sline_d   = LineW'(idx);
        scnt_d    = CntW'(serve_cnt);
      end else begin
        disp_d    = 1'b0;
        hold_d    = 1'b0;
        cur_d     = '0;
        cur_cnt_d = '0;
        kind_d    = frr_d ? did_pkg::KIND_DONE_SCHED : did_pkg::KIND_DONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= '0;
      hold_q    <= 1'b0;
      disp_q    <= 1'b0;
      cur_q     <= '0;
      cur_cnt_q <= '0;
      frr_q     <= 1'b0;
    end else if (item_v_q) begin
      pend_q    <= pend_d;
      hold_q    <= hold_d;
      disp_q    <= disp_d;
      cur_q     <= cur_d;
      cur_cnt_q <= cur_cnt_d;
      frr_q     <= frr_d;
    end
  end

  // ---------------- result register ----------------
  logic                  done_q;
  did_pkg::kind_e        kind_q;
  logic [LineW-1:0]      sline_q;
  logic [CntW-1:0]       scnt_q;
  logic                  prev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= item_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_v_q) begin
      kind_q  <= kind_d;
      sline_q <= sline_d;
      scnt_q  <= scnt_d;
      prev_q  <= prev_d;
    end
  end

  assign done_o          = done_q;
  assign kind_o          = kind_q;
  assign served_line_o   = sline_q;
  assign served_count_o  = scnt_q;
  assign previous_hold_o = prev_q;

endmodule

>>> rtl/did_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// did_port_checks
// Port-level checks of the dispatcher core, bound into the core module.
// ----------------------------------------------------------------------------
module did_port_checks (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             start,
  input logic                             busy,
  input logic                             done_o,
  input logic [did_pkg::KIND_W-1:0]       kind_o,
  input logic [did_pkg::LINE_W-1:0]       served_line_o,
  input logic [did_pkg::COUNT_OUT_W-1:0]  served_count_o,
  input logic                             previous_hold_o
);

  // every accepted request is answered through the input and result registers
  a_req_answered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 done_o)
    else $error("accepted request got no result");

  // no result without a request
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 2))
    else $error("result without request");

  // line and count are only carried by dispatches
  a_payload_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (kind_o != did_pkg::KIND_DISPATCH)) |->
      ((served_line_o == '0) && (served_count_o == '0)))
    else $error("served fields set outside dispatch");

  // a save sets the hold flag, so a save right after it sees it set
  a_save_sets_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (kind_o == did_pkg::KIND_SAVE)) ##1
      (done_o && (kind_o == did_pkg::KIND_SAVE)) |-> previous_hold_o)
    else $error("back-to-back save lost hold flag");

endmodule

bind deferred_irq_dispatcher_core did_port_checks u_did_checker (.*);

>>> tb/did_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// did_checker
// Watches the request, result and register channels of the interrupt
// dispatcher, predicts each reply from its own copy of the pending state and
// compares the replies field by field, oldest first.
// ----------------------------------------------------------------------------
module did_checker
  import did_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  input  logic                    busy,
  input  logic [ACTION_W-1:0]     action_i,
  input  logic [LINE_W-1:0]       line_number_i,
  input  logic                    retry_i,
  input  logic                    restore_value_i,
  input  logic                    done_i,
  input  logic [KIND_W-1:0]       kind_i,
  input  logic [LINE_W-1:0]       served_line_i,
  input  logic [COUNT_OUT_W-1:0]  served_count_i,
  input  logic                    previous_hold_i,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ADDR_W-1:0]       paddr,
  input  logic [REG_W-1:0]        pwdata,
  input  logic [REG_W-1:0]        prdata,
  input  logic                    pready,
  output int                      fail_count_o,
  output int                      outstanding_o,
  output int                      checked_o,
  output int                      dispatches_o
);

  localparam logic [ADDR_W-1:0] ENABLE_ADDR = ADDR_W'(REG_HANDLER_ENABLE * 4);

  typedef struct packed {
    kind_e                   kind;
    logic [LINE_W-1:0]       line;
    logic [COUNT_OUT_W-1:0]  count;
    logic                    prev_hold;
  } irq_reply_t;

  // predicted block state
  logic [31:0] handler_mask;
  logic [31:0] pend_mask;
  logic [31:0] line_counts [32];
  logic        held;
  logic        in_run;
  logic        from_raise;
  logic [4:0]  cur_line;
  logic [31:0] cur_count;

  irq_reply_t  predicted_replies [$];
  irq_reply_t  oldest;
  int          pushed;
  int          popped;

  function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
    logic [32:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

  // Serve the highest pending line with a handler and a count, dropping the
  // pending lines passed over; with nothing left the run ends.
  function automatic irq_reply_t next_service();
    irq_reply_t r;
    logic       found;
    int         i;
    r = '0;
    r.kind = KIND_ACCEPTED;
    found = 1'b0;
    for (i = 31; i >= 0; i--) begin
      if (!found && pend_mask[i]) begin
        pend_mask[i] = 1'b0;
        if (handler_mask[i] && line_counts[i] != 0) begin
          found     = 1'b1;
          cur_line  = 5'(i);
          cur_count = line_counts[i];
          line_counts[i] = '0;
          in_run    = 1'b1;
          r.kind    = KIND_DISPATCH;
          r.line    = 5'(i);
          r.count   = cur_count;
        end
      end
    end
    if (!found) begin
      in_run    = 1'b0;
      held      = 1'b0;
      cur_line  = '0;
      cur_count = '0;
      r.kind    = from_raise ? KIND_DONE_SCHED : KIND_DONE;
    end
    return r;
  endfunction

  function automatic irq_reply_t apply_request(logic [ACTION_W-1:0] act, logic [LINE_W-1:0] ln,
                                               logic rt, logic rv);
    irq_reply_t r;
    r = '0;
    r.kind = KIND_ACCEPTED;
    case (action_e'(act))
      ACT_RAISE: begin
        pend_mask[ln]   = 1'b1;
        line_counts[ln] = sat_add(line_counts[ln], 32'd1);
        if (!held && !in_run) begin
          held       = 1'b1;
          from_raise = 1'b1;
          r = next_service();
        end
      end
      ACT_DONE: begin
        if (in_run) begin
          // retry returns the count but leaves the pending bit clear
          if (rt) line_counts[cur_line] = sat_add(line_counts[cur_line], cur_count);
          cur_count = '0;
          r = next_service();
        end
      end
      ACT_SAVE: begin
        r.kind      = KIND_SAVE;
        r.prev_hold = held;
        held        = 1'b1;
      end
      default: begin
        if (!in_run && !rv && pend_mask != 0) begin
          from_raise = 1'b0;
          r = next_service();
        end else begin
          held = rv;
        end
      end
    endcase
    return r;
  endfunction

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      handler_mask = '0;
      pend_mask    = '0;
      foreach (line_counts[i]) line_counts[i] = '0;
      held         = 1'b0;
      in_run       = 1'b0;
      from_raise   = 1'b0;
      cur_line     = '0;
      cur_count    = '0;
      predicted_replies.delete();
      fail_count_o  = 0;
      checked_o     = 0;
      dispatches_o  = 0;
      outstanding_o <= 0;
    end else begin
      pushed = 0;
      popped = 0;
      if (psel && penable && pready && paddr == ENABLE_ADDR) begin
        if (pwrite) begin
          handler_mask = pwdata;
        end else begin
          compare_field("prdata", handler_mask, prdata);
        end
      end
      if (done_i) begin
        if (predicted_replies.size() == 0) begin
          $error("result with no request waiting: kind %0d", kind_i);
          fail_count_o++;
        end else begin
          oldest = predicted_replies.pop_front();
          popped = 1;
          checked_o++;
          if (kind_i == KIND_DISPATCH) dispatches_o++;
          compare_field("kind", 32'(oldest.kind), 32'(kind_i));
          compare_field("served_line", 32'(oldest.line), 32'(served_line_i));
          compare_field("served_count", oldest.count, served_count_i);
          compare_field("previous_hold", 32'(oldest.prev_hold), 32'(previous_hold_i));
        end
      end
      if (start && !busy) begin
        predicted_replies.push_back(apply_request(action_i, line_number_i, retry_i,
                                                  restore_value_i));
        pushed = 1;
      end
      outstanding_o <= outstanding_o + pushed - popped;
    end
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the interrupt dispatcher with directed and random requests under
// several handler-enable settings, with random request gaps and bursts.
// ----------------------------------------------------------------------------
module tb_top;
  import did_pkg::*;

  localparam int PHASE_ITEMS = 290;
  localparam int CYCLE_LIMIT = 400000;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic [ACTION_W-1:0]     action_i;
  logic [LINE_W-1:0]       line_number_i;
  logic                    retry_i;
  logic                    restore_value_i;
  logic                    done_o;
  logic [KIND_W-1:0]       kind_o;
  logic [LINE_W-1:0]       served_line_o;
  logic [COUNT_OUT_W-1:0]  served_count_o;
  logic                    previous_hold_o;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [ADDR_W-1:0]       paddr;
  logic [REG_W-1:0]        pwdata;
  logic [REG_W-1:0]        prdata;
  logic                    pready;

  int fail_count;
  int outstanding;
  int checked;
  int dispatches;
  int cycles = 0;
  int sent;
  int settings_used;
  logic burst;

  logic [31:0] enable_settings [6];

  deferred_irq_dispatcher_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .action_i       (action_i),
    .line_number_i  (line_number_i),
    .retry_i        (retry_i),
    .restore_value_i(restore_value_i),
    .done_o         (done_o),
    .kind_o         (kind_o),
    .served_line_o  (served_line_o),
    .served_count_o (served_count_o),
    .previous_hold_o(previous_hold_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  did_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .action_i       (action_i),
    .line_number_i  (line_number_i),
    .retry_i        (retry_i),
    .restore_value_i(restore_value_i),
    .done_i         (done_o),
    .kind_i         (kind_o),
    .served_line_i  (served_line_o),
    .served_count_i (served_count_o),
    .previous_hold_i(previous_hold_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .fail_count_o   (fail_count),
    .outstanding_o  (outstanding),
    .checked_o      (checked),
    .dispatches_o   (dispatches)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // One request; start stays high when the next one follows with no gap.
  task automatic send(action_e act, logic [LINE_W-1:0] ln, logic rt, logic rv);
    int gap;
    gap = burst ? 0 : ($urandom_range(0, 1) ? 0 : $urandom_range(1, 17));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start           <= 1'b1;
    action_i        <= act;
    line_number_i   <= ln;
    retry_i         <= rt;
    restore_value_i <= rv;
    do @(posedge clk_i); while (busy);
    sent++;
  endtask

  task automatic random_request();
    int          pick;
    action_e     act;
    logic [4:0]  ln;
    pick = $urandom_range(0, 99);
    if (pick < 45)      act = ACT_RAISE;
    else if (pick < 75) act = ACT_DONE;
    else if (pick < 85) act = ACT_SAVE;
    else                act = ACT_RESTORE;
    // half the raises hit a few lines so counts build up
    ln = $urandom_range(0, 1) ? 5'($urandom_range(0, 31))
                              : {$urandom_range(0, 1) ? 3'b111 : 3'b000, 2'($urandom_range(0, 3))};
    send(act, ln, 1'($urandom_range(0, 1)), ($urandom_range(0, 9) < 3));
  endtask

  // Lower start and let every predicted reply come back, plus the pipeline.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic reg_access(logic wr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_W'(REG_HANDLER_ENABLE * 4);
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_handlers(logic [31:0] mask);
    reg_access(1'b1, mask);
    reg_access(1'b0, '0);
    settings_used++;
  endtask

  initial begin
    rst_ni          <= 1'b0;
    start           <= 1'b0;
    action_i        <= '0;
    line_number_i   <= '0;
    retry_i         <= 1'b0;
    restore_value_i <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    sent          = 0;
    settings_used = 0;
    burst         = 1'b0;
    enable_settings[0] = 32'hFFFF_FFFF;
    enable_settings[1] = 32'h0000_0000;
    enable_settings[2] = $urandom;
    enable_settings[3] = 32'h5555_AAAA;
    enable_settings[4] = 32'h8000_0001;
    enable_settings[5] = $urandom;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i); while (busy);

    // directed: lines 0 and 15 have no handler
    set_handlers(32'hFFFF_7FFE);
    send(ACT_DONE, 5'd0, 1'b1, 1'b0);      // done outside a run
    send(ACT_SAVE, 5'd0, 1'b0, 1'b0);      // hold flag set
    send(ACT_RAISE, 5'd0, 1'b0, 1'b0);     // raises while held
    send(ACT_RAISE, 5'd31, 1'b0, 1'b0);
    send(ACT_RAISE, 5'd15, 1'b0, 1'b0);
    send(ACT_RAISE, 5'd31, 1'b0, 1'b0);
    send(ACT_RESTORE, 5'd0, 1'b0, 1'b0);   // restore starts a run
    send(ACT_RESTORE, 5'd0, 1'b0, 1'b1);   // restore during a run
    send(ACT_SAVE, 5'd0, 1'b0, 1'b0);      // save during a run
    send(ACT_RAISE, 5'd5, 1'b0, 1'b0);     // raise during a run
    send(ACT_DONE, 5'd0, 1'b1, 1'b0);      // retry, drop line 15
    send(ACT_DONE, 5'd0, 1'b0, 1'b0);      // drop line 0, run ends
    send(ACT_RAISE, 5'd31, 1'b0, 1'b0);    // retried count comes back
    send(ACT_DONE, 5'd0, 1'b0, 1'b0);
    send(ACT_RAISE, 5'd0, 1'b0, 1'b0);     // no handler: run ends at once
    send(ACT_RESTORE, 5'd31, 1'b1, 1'b1);
    send(ACT_RESTORE, 5'd31, 1'b1, 1'b0);  // nothing pending: just clears
    send(ACT_SAVE, 5'd31, 1'b1, 1'b1);
    send(ACT_RESTORE, 5'd0, 1'b0, 1'b0);
    send(ACT_RAISE, 5'd1, 1'b0, 1'b0);
    send(ACT_RAISE, 5'd2, 1'b1, 1'b1);
    send(ACT_DONE, 5'd0, 1'b1, 1'b0);
    send(ACT_DONE, 5'd31, 1'b1, 1'b1);
    send(ACT_RAISE, 5'd2, 1'b0, 1'b0);
    send(ACT_DONE, 5'd0, 1'b0, 1'b0);
    drain();

    foreach (enable_settings[p]) begin
      set_handlers(enable_settings[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) burst = ($urandom_range(0, 2) == 0);
        random_request();
      end
      drain();
    end

    repeat (8) @(posedge clk_i);
    $display("Ran %0d requests over %0d handler-enable settings.", sent, settings_used);
    $display("Checked %0d results, %0d of them dispatches.", checked, dispatches);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> deferred_irq_dispatcher_core.f
rtl/did_pkg.sv
rtl/did_count_lanes.sv
rtl/deferred_irq_dispatcher_core.sv
rtl/did_checker.sv
tb/did_checker.sv
tb/tb_top.sv
